[design/tcc_pkg.sv]
package tcc_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CELL_W = 16;

    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [7:0]  BLANK_ATTR   = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, SPACE_CODE};

    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] MOVE_LAST  = ADDR_W'(CELL_COUNT - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] FILL_LAST  = ADDR_W'(CELL_COUNT - 1);

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SCROLL_RD = 5'b00010,
        ST_SCROLL_WR = 5'b00100,
        ST_FILL     = 5'b01000,
        ST_DONE     = 5'b10000
    } state_t;

    typedef struct packed {
        logic accept;
        logic move_rd;
        logic move_wr;
        logic fill_wr;
        logic out_load;
    } tcc_cmd_t;

    typedef struct packed {
        logic put_scrolls;
        logic move_last;
        logic fill_last;
        logic out_free;
    } tcc_status_t;

endpackage

[design/tcc_ctrl.sv]
module tcc_ctrl
    import tcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  tcc_status_t status,
    output tcc_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    case (s_op)
                        OP_PUT:   state_next = status.put_scrolls ? ST_SCROLL_RD : ST_DONE;
                        OP_CLEAR: state_next = ST_FILL;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCROLL_RD: begin
                cmd.move_rd = 1'b1;
                state_next  = ST_SCROLL_WR;
            end
            ST_SCROLL_WR: begin
                cmd.move_wr = 1'b1;
                state_next  = status.move_last ? ST_FILL : ST_SCROLL_RD;
            end
            ST_FILL: begin
                cmd.fill_wr = 1'b1;
                if (status.fill_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/tcc_datapath.sv]
module tcc_datapath
    import tcc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  tcc_cmd_t          cmd,
    output tcc_status_t       status,
    input  logic [1:0]        s_op,
    input  logic [7:0]        s_char_code,
    input  logic [3:0]        s_color,
    input  logic [ROW_W-1:0]  s_read_row,
    input  logic [COL_W-1:0]  s_read_col,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ROW_W-1:0]  m_cursor_row,
    output logic [COL_W-1:0]  m_cursor_col,
    output logic [10:0]       m_cursor_offset,
    output logic              m_scrolled,
    output logic [7:0]        m_cell_char,
    output logic [7:0]        m_cell_attr
);

    logic [CELL_W-1:0] mem [CELL_COUNT];

    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic [CELL_W-1:0] rd_data_reg;
    logic              show_cell_reg;
    logic              scrolled_reg;

    logic              m_valid_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [COL_W-1:0]  m_col_reg;
    logic [10:0]       m_offset_reg;
    logic              m_scrolled_reg;
    logic [7:0]        m_char_reg;
    logic [7:0]        m_attr_reg;

    logic              is_put;
    logic              is_clear;
    logic              is_read;
    logic              newline;
    logic              wrap;
    logic              in_range;
    logic [ADDR_W-1:0] cursor_addr;
    logic [ADDR_W-1:0] read_addr;

    logic              we;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              re;
    logic [ADDR_W-1:0] rd_addr;

    assign is_put      = (s_op == OP_PUT);
    assign is_clear    = (s_op == OP_CLEAR);
    assign is_read     = (s_op == OP_READ);
    assign newline     = (s_char_code == NEWLINE_CODE);
    assign wrap        = newline || (col_reg == COL_LAST);
    assign in_range    = (s_read_row <= ROW_LAST) && (s_read_col <= COL_LAST);
    assign cursor_addr = base_reg + ADDR_W'(col_reg);
    assign read_addr   = ADDR_W'(s_read_row) * ROW_STRIDE + ADDR_W'(s_read_col);

    assign status.put_scrolls = wrap && (row_reg == ROW_LAST);
    assign status.move_last   = (cnt_reg == MOVE_LAST);
    assign status.fill_last   = (cnt_reg == FILL_LAST);
    assign status.out_free    = !m_valid_reg || m_ready;

    always_comb begin
        we      = 1'b0;
        wr_addr = cnt_reg;
        wr_data = BLANK_CELL;
        if (cmd.accept) begin
            we      = is_put && !newline;
            wr_addr = cursor_addr;
            wr_data = {4'b0000, s_color, s_char_code};
        end else if (cmd.move_wr) begin
            we      = 1'b1;
            wr_data = rd_data_reg;
        end else if (cmd.fill_wr) begin
            we      = 1'b1;
        end
    end

    always_comb begin
        re      = 1'b0;
        rd_addr = cnt_reg + ROW_STRIDE;
        if (cmd.accept) begin
            re      = is_read && in_range;
            rd_addr = read_addr;
        end else if (cmd.move_rd) begin
            re      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            base_reg <= '0;
        end else if (cmd.accept) begin
            if (is_put) begin
                if (wrap) begin
                    col_reg <= '0;
                    if (row_reg != ROW_LAST) begin
                        row_reg  <= row_reg + 1'b1;
                        base_reg <= base_reg + ROW_STRIDE;
                    end
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end else if (is_clear) begin
                row_reg  <= '0;
                col_reg  <= '0;
                base_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.accept) begin
            cnt_reg <= '0;
        end else if (cmd.move_wr || cmd.fill_wr) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            show_cell_reg <= is_read && in_range;
            scrolled_reg  <= is_put && status.put_scrolls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_row_reg      <= row_reg;
            m_col_reg      <= col_reg;
            m_offset_reg   <= 11'(cursor_addr);
            m_scrolled_reg <= scrolled_reg;
            m_char_reg     <= show_cell_reg ? rd_data_reg[7:0]  : 8'h00;
            m_attr_reg     <= show_cell_reg ? rd_data_reg[15:8] : 8'h00;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cursor_row    = m_row_reg;
    assign m_cursor_col    = m_col_reg;
    assign m_cursor_offset = m_offset_reg;
    assign m_scrolled      = m_scrolled_reg;
    assign m_cell_char     = m_char_reg;
    assign m_cell_attr     = m_attr_reg;

endmodule

[design/text_console_char_writer.sv]
// Text console character writer: a ROWS x COLUMNS store of char/attribute cells
// and a cursor. The s_ channel takes one operation per transfer (put char,
// clear, read cell); the m_ channel returns one result per operation with the
// cursor position, linear offset, scroll flag and the read cell.
// Every operation ends in ST_DONE, which loads the result register once it is
// free; s_ready is high only in ST_IDLE, so no new input is taken before the
// last result is loaded. A put that wraps off the last row scrolls the screen:
// each of the CELL_COUNT - COLUMNS moved cells is read, then written, through
// the one read and one write port of the cell memory, then the COLUMNS cells
// of the last row are blanked. A clear writes every cell once. s_ready is low
// while a scroll or clear sweeps the memory.
// Reset homes the cursor and empties the result register; the cell memory is
// not cleared, so issue a clear before reading cells that were never written.
// The result register holds its transfer while m_ready is low; one further
// input is accepted and worked on, and its result waits until the register
// frees.
module text_console_char_writer
    import tcc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic [7:0]        s_char_code,
    input  logic [3:0]        s_color,
    input  logic [ROW_W-1:0]  s_read_row,
    input  logic [COL_W-1:0]  s_read_col,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ROW_W-1:0]  m_cursor_row,
    output logic [COL_W-1:0]  m_cursor_col,
    output logic [10:0]       m_cursor_offset,
    output logic              m_scrolled,
    output logic [7:0]        m_cell_char,
    output logic [7:0]        m_cell_attr
);

    tcc_cmd_t    cmd;
    tcc_status_t status;

    tcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .status  (status),
        .cmd     (cmd)
    );

    tcc_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_op            (s_op),
        .s_char_code     (s_char_code),
        .s_color         (s_color),
        .s_read_row      (s_read_row),
        .s_read_col      (s_read_col),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_col    (m_cursor_col),
        .m_cursor_offset (m_cursor_offset),
        .m_scrolled      (m_scrolled),
        .m_cell_char     (m_cell_char),
        .m_cell_attr     (m_cell_attr)
    );

endmodule

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcc_pkg::*;

    localparam int RANDOM_ITEMS  = 660;
    localparam int SCROLL_BUDGET = 80;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 16;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [10:0]      offset;
        logic             scrolled;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
    } console_result_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } rx_mode_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [1:0]       s_op = OP_NOP;
    logic [7:0]       s_char_code = '0;
    logic [3:0]       s_color = '0;
    logic [ROW_W-1:0] s_read_row = '0;
    logic [COL_W-1:0] s_read_col = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [ROW_W-1:0] m_cursor_row;
    logic [COL_W-1:0] m_cursor_col;
    logic [10:0]      m_cursor_offset;
    logic             m_scrolled;
    logic [7:0]       m_cell_char;
    logic [7:0]       m_cell_attr;

    logic [CELL_W-1:0] screen_cells [CELL_COUNT];
    bit                cell_written [CELL_COUNT];
    int                cur_row = 0;
    int                cur_col = 0;
    int                scroll_count = 0;

    console_result_t expected_results [$];
    int              err_count = 0;

    bit idle_en = 1'b0;
    int burst_left = 0;

    int       hold_seq = 0;
    int       hold_seen = 0;
    int       hold_left = 0;
    rx_mode_t rx_mode = RX_ALWAYS;
    int       rx_phase_left = 0;
    int       rx_tick = 0;

    text_console_char_writer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_char_code     (s_char_code),
        .s_color         (s_color),
        .s_read_row      (s_read_row),
        .s_read_col      (s_read_col),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_col    (m_cursor_col),
        .m_cursor_offset (m_cursor_offset),
        .m_scrolled      (m_scrolled),
        .m_cell_char     (m_cell_char),
        .m_cell_attr     (m_cell_attr)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("text_console_char_writer: mismatch");
        $finish;
    end

    function automatic console_result_t predict_console(op_t op, logic [7:0] ch,
                                                        logic [3:0] color,
                                                        logic [ROW_W-1:0] rr,
                                                        logic [COL_W-1:0] rc);
        console_result_t res;
        int idx;
        res = '0;
        case (op)
            OP_PUT: begin
                if (ch != NEWLINE_CODE) begin
                    idx = cur_row * COLUMNS + cur_col;
                    screen_cells[idx] = {4'h0, color, ch};
                    cell_written[idx] = 1'b1;
                end
                if (ch == NEWLINE_CODE || cur_col == COLUMNS - 1) begin
                    cur_col = 0;
                    if (cur_row == ROWS - 1) begin
                        for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
                            screen_cells[i] = screen_cells[i + COLUMNS];
                            cell_written[i] = cell_written[i + COLUMNS];
                        end
                        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
                            screen_cells[i] = BLANK_CELL;
                            cell_written[i] = 1'b1;
                        end
                        res.scrolled = 1'b1;
                        scroll_count++;
                    end else begin
                        cur_row++;
                    end
                end else begin
                    cur_col++;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++) begin
                    screen_cells[i] = BLANK_CELL;
                    cell_written[i] = 1'b1;
                end
                cur_row = 0;
                cur_col = 0;
            end
            OP_READ: begin
                if (rr < ROWS && rc < COLUMNS) begin
                    idx = rr * COLUMNS + rc;
                    res.cell_char = screen_cells[idx][7:0];
                    res.cell_attr = screen_cells[idx][15:8];
                end
            end
            default: begin
            end
        endcase
        res.row    = ROW_W'(cur_row);
        res.col    = COL_W'(cur_col);
        res.offset = 11'(cur_row * COLUMNS + cur_col);
        return res;
    endfunction

    task automatic send_item(op_t op, logic [7:0] ch, logic [3:0] color,
                             logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
        int gap;
        gap = 0;
        if (idle_en) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_char_code <= ch;
        s_color     <= color;
        s_read_row  <= rr;
        s_read_col  <= rc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(predict_console(op, ch, color, rr, rc));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // in-range reads only land on cells that hold something
    task automatic pick_read_target(output logic [ROW_W-1:0] rr, output logic [COL_W-1:0] rc);
        int tries;
        tries = 0;
        if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 1) begin
                rr = ROW_W'($urandom_range(ROWS, 31));
                rc = COL_W'($urandom);
            end else begin
                rr = ROW_W'($urandom);
                rc = COL_W'($urandom_range(COLUMNS, 127));
            end
        end else begin
            do begin
                rr = ROW_W'($urandom_range(0, ROWS - 1));
                rc = COL_W'($urandom_range(0, COLUMNS - 1));
                tries++;
            end while (!cell_written[rr * COLUMNS + rc] && tries < 32);
            if (!cell_written[rr * COLUMNS + rc])
                rc = COL_W'($urandom_range(COLUMNS, 127));
        end
    endtask

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            err_count++;
            $display("%0t %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        console_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                err_count++;
                $display("%0t unexpected transfer: expected none, actual row %0d col %0d",
                         $time, m_cursor_row, m_cursor_col);
            end else begin
                exp_r = expected_results.pop_front();
                check_field("cursor_row", 16'(exp_r.row), 16'(m_cursor_row));
                check_field("cursor_col", 16'(exp_r.col), 16'(m_cursor_col));
                check_field("cursor_offset", 16'(exp_r.offset), 16'(m_cursor_offset));
                check_field("scrolled", 16'(exp_r.scrolled), 16'(m_scrolled));
                check_field("cell_char", 16'(exp_r.cell_char), 16'(m_cell_char));
                check_field("cell_attr", 16'(exp_r.cell_attr), 16'(m_cell_attr));
            end
        end
    end

    always @(posedge aclk) begin
        rx_tick++;
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (rx_phase_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_phase_left = $urandom_range(16, 200);
        end else begin
            rx_phase_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:   m_ready <= 1'b1;
                RX_COIN:     m_ready <= ($urandom_range(0, 1) == 1);
                RX_MOSTLY:   m_ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: m_ready <= ((rx_tick % 5) < 2);
                default:     m_ready <= 1'b1;
            endcase
        end
    end

    task automatic test_directed_ops();
        idle_en = 1'b1;
        send_item(OP_PUT, 8'h41, 4'hF, '0, '0);
        send_item(OP_READ, 8'h00, 4'h0, '0, '0);
        send_item(OP_READ, 8'hFF, 4'hF, 5'd31, 7'd127);
        send_item(OP_READ, 8'h00, 4'h0, ROW_W'(ROWS), '0);
        send_item(OP_READ, 8'h00, 4'h0, '0, COL_W'(COLUMNS));
        send_item(OP_NOP, 8'hFF, 4'hF, 5'd31, 7'd127);
        send_item(OP_PUT, NEWLINE_CODE, 4'h5, '0, '0);
        send_item(OP_PUT, 8'h00, 4'h0, 5'd31, 7'd127);
        send_item(OP_READ, 8'h00, 4'h0, 5'd1, '0);
        send_item(OP_CLEAR, 8'hFF, 4'hF, 5'd31, 7'd127);
        send_item(OP_READ, 8'h00, 4'h0, ROW_LAST, COL_LAST);
        send_item(OP_READ, 8'h00, 4'h0, '0, '0);
        send_item(OP_PUT, 8'hFF, 4'h0, '0, '0);
        send_item(OP_PUT, 8'h7E, 4'hA, '0, '0);
        send_item(OP_PUT, NEWLINE_CODE, 4'hF, '0, '0);
        send_item(OP_READ, 8'h00, 4'h0, '0, '0);
        send_item(OP_READ, 8'h00, 4'h0, '0, 7'd1);
        send_item(OP_READ, 8'h00, 4'h0, '0, 7'd2);
        send_item(OP_NOP, 8'h00, 4'h0, '0, '0);
        send_item(OP_PUT, SPACE_CODE, 4'h8, '0, '0);
        send_item(OP_READ, 8'h00, 4'h0, 5'd1, '0);
    endtask

    task automatic test_result_backpressure();
        logic [ROW_W-1:0] rr;
        logic [COL_W-1:0] rc;
        send_item(OP_CLEAR, 8'($urandom), 4'($urandom), ROW_W'($urandom), COL_W'($urandom));
        wait_drained();
        idle_en = 1'b0;
        hold_seq <= hold_seq + 1;
        repeat (12) begin
            send_item(OP_PUT, 8'($urandom), 4'($urandom), ROW_W'($urandom), COL_W'($urandom));
            pick_read_target(rr, rc);
            send_item(OP_READ, 8'($urandom), 4'($urandom), rr, rc);
        end
        wait_drained();
    endtask

    task automatic test_random_sessions();
        int sent;
        int span;
        int nl_pct;
        int pick;
        logic [7:0] ch;
        logic [ROW_W-1:0] rr;
        logic [COL_W-1:0] rc;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_en = ($urandom_range(0, 3) != 0);
            span = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
                0:       nl_pct = 0;
                1:       nl_pct = 30;
                default: nl_pct = 5;
            endcase
            if ($urandom_range(0, 3) == 0) begin
                send_item(OP_CLEAR, 8'($urandom), 4'($urandom), ROW_W'($urandom),
                          COL_W'($urandom));
                sent++;
            end
            repeat (span) begin
                pick = $urandom_range(0, 99);
                ch = 8'($urandom);
                rr = ROW_W'($urandom);
                rc = COL_W'($urandom);
                if (pick < 1) begin
                    send_item(OP_CLEAR, ch, 4'($urandom), rr, rc);
                end else if (pick < 4) begin
                    send_item(OP_NOP, ch, 4'($urandom), rr, rc);
                end else if (pick < 30) begin
                    pick_read_target(rr, rc);
                    send_item(OP_READ, ch, 4'($urandom), rr, rc);
                end else begin
                    if ($urandom_range(0, 99) < nl_pct)
                        ch = NEWLINE_CODE;
                    // hold the number of full-screen scrolls down
                    if ((ch == NEWLINE_CODE || cur_col == COLUMNS - 1) &&
                        cur_row == ROWS - 1 && scroll_count >= SCROLL_BUDGET) begin
                        pick_read_target(rr, rc);
                        send_item(OP_READ, ch, 4'($urandom), rr, rc);
                    end else begin
                        send_item(OP_PUT, ch, 4'($urandom), rr, rc);
                    end
                end
                sent++;
            end
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_ops();
        test_result_backpressure();
        test_random_sessions();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("text_console_char_writer: match");
        else
            $display("text_console_char_writer: mismatch");
        $finish;
    end

endmodule
